// ----- design/mexp_pkg.sv -----
// Shared constants, status type and modular add helper for the modular
// exponentiation unit. No dependencies.
package mexp_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// Handshake status of a serial unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// (a + b) mod m for a, b < m; one wide add, one compare and subtract.
	function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
		logic [WORD_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		return sum[WORD_BITS-1:0];
	endfunction

endpackage

// ----- design/mexp_reduce.sv -----
// Bit-serial restoring reduction: shifts the message in one bit per cycle
// and keeps the partial remainder below the modulus. Uses mexp_pkg.
module mexp_reduce import mexp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  word_t      value,
	input  word_t      modulus,
	output word_t      rem,
	output unit_stat_t stat
);

	word_t              shift_q;
	word_t              rem_q;
	cnt_t               cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [WORD_BITS:0] trial;

	always_comb begin
		trial = {rem_q, shift_q[WORD_BITS-1]};
		if (trial >= {1'b0, modulus}) begin
			trial = trial - {1'b0, modulus};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= cnt_t'(WORD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= value;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[WORD_BITS-2:0], 1'b0};
			rem_q   <= trial[WORD_BITS-1:0];
		end
	end

	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- design/mexp_mulmod.sv -----
// Bit-serial interleaved modular multiplier: scans the multiplier MSB first,
// doubling mod m each bit and adding the multiplicand on a one. Uses mexp_pkg.
module mexp_mulmod import mexp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  word_t      a,
	input  word_t      b,
	input  word_t      modulus,
	output word_t      prod,
	output unit_stat_t stat
);

	word_t acc_q;
	word_t a_q;
	word_t b_q;
	cnt_t  cnt_q;
	logic  busy_q;
	logic  done_q;
	logic  add_phase_q;
	logic  bit_end;
	word_t step_sum;

	// Doubling phase ends the bit on a zero; the add phase always ends it.
	assign bit_end  = busy_q && (add_phase_q || !b_q[WORD_BITS-1]);
	assign step_sum = add_phase_q ? add_mod(acc_q, a_q, modulus)
	                              : add_mod(acc_q, acc_q, modulus);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			add_phase_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q      <= 1'b1;
				add_phase_q <= 1'b0;
				cnt_q       <= cnt_t'(WORD_BITS - 1);
			end else if (busy_q) begin
				if (bit_end) begin
					add_phase_q <= 1'b0;
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end else begin
					add_phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= step_sum;
			if (bit_end) begin
				b_q <= {b_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- design/modular_exponentiation_unit.sv -----
// Top level: configuration registers, square-and-multiply sequencer, output
// register. Uses mexp_pkg, mexp_reduce and mexp_mulmod.
//
// Computes result_word = (message_word mod modulus) ^ exponent mod modulus.
// Input beats arrive on in_valid/in_ready with message_word; result beats
// leave on out_valid/out_ready with result_word, one result per input.
// Registers: index 0 is the exponent (reset 1), index 1 the modulus (reset 2),
// written through cfg_we/cfg_index/cfg_data, by the user only while no item is in flight (not enforced).
// A modulus of 0 or 1 gives result 0. Otherwise the message is first reduced
// one bit per cycle, then every exponent bit from the top down costs one
// modular square and, on a one, one modular multiply. Each multiply runs on
// one shared bit-serial unit, whose serial loop over the multiplier's bits
// sets how long one item takes.
// One item is processed at a time; in_ready is high whenever the sequencer
// is idle, also while a finished result waits in the output register.
// If the receiver stalls, the next result holds in the sequencer until the
// output register frees. Reset restores the register defaults and drops
// any item in flight.
module modular_exponentiation_unit import mexp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  word_t message_word,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t result_word,
	input  logic  cfg_we,
	input  logic  cfg_index,
	input  word_t cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;

	logic [2:0] state_q;
	word_t      exponent_q;
	word_t      modulus_q;
	word_t      exp_sh_q;
	cnt_t       bits_q;
	word_t      base_q;
	word_t      acc_q;
	word_t      opa_q;
	word_t      opb_q;
	logic       red_go_q;
	logic       mul_go_q;
	logic       out_valid_q;
	word_t      result_q;

	word_t      red_rem;
	unit_stat_t red_stat;
	word_t      prod;
	unit_stat_t mul_stat;
	logic       advance;
	logic       out_free;

	mexp_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_go_q),
		.value   (exp_sh_q),
		.modulus (modulus_q),
		.rem     (red_rem),
		.stat    (red_stat)
	);

	mexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go_q),
		.a       (opa_q),
		.b       (opb_q),
		.modulus (modulus_q),
		.prod    (prod),
		.stat    (mul_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= word_t'(1);
			modulus_q  <= word_t'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data;
				REG_MODULUS:  modulus_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	// Close one exponent bit: after a square on a zero, or after the multiply.
	assign advance  = mul_stat.done &&
	                  ((state_q == ST_MUL) ||
	                   (state_q == ST_SQR && !exp_sh_q[WORD_BITS-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			red_go_q    <= 1'b0;
			mul_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			bits_q      <= '0;
		end else begin
			red_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				ST_IDLE: begin
					if (in_valid) begin
						if (modulus_q < word_t'(2)) begin
							state_q <= ST_DONE;
						end else begin
							red_go_q <= 1'b1;
							bits_q   <= cnt_t'(WORD_BITS - 1);
							state_q  <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (red_stat.done) begin
						mul_go_q <= 1'b1;
						state_q  <= ST_SQR;
					end
				end
				ST_SQR, ST_MUL: begin
					if (mul_stat.done && !advance) begin
						mul_go_q <= 1'b1;
						state_q  <= ST_MUL;
					end else if (advance) begin
						if (bits_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							bits_q   <= bits_q - 1'b1;
							mul_go_q <= 1'b1;
							state_q  <= ST_SQR;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload path: message shift register doubles as reduction input and
	// then holds the exponent, scanned MSB first.
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				exp_sh_q <= message_word;
				acc_q    <= '0;
			end
			ST_RED: begin
				if (red_stat.done) begin
					base_q   <= red_rem;
					exp_sh_q <= exponent_q;
					acc_q    <= word_t'(1);
					opa_q    <= word_t'(1);
					opb_q    <= word_t'(1);
				end
			end
			ST_SQR, ST_MUL: begin
				if (mul_stat.done && !advance) begin
					acc_q <= prod;
					opa_q <= prod;
					opb_q <= base_q;
				end else if (advance) begin
					acc_q    <= prod;
					opa_q    <= prod;
					opb_q    <= prod;
					exp_sh_q <= {exp_sh_q[WORD_BITS-2:0], 1'b0};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					result_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result_word = result_q;

`ifndef SYNTHESIS
	a_mul_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mul_go_q |-> !mul_stat.busy)
		else $error("multiplier restarted while busy");

	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!mul_stat.busy && !red_stat.busy))
		else $error("serial unit busy while sequencer idle");

	a_mul_done_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_SQR || state_q == ST_MUL))
		else $error("multiplier finished outside the exponent loop");

	a_red_done_in_red: assert property (@(posedge clk) disable iff (!arst_n)
		red_stat.done |-> (state_q == ST_RED))
		else $error("reduction finished outside its state");
`endif

endmodule
